// ===== design/gradient_noise_3d_defines.svh =====
// ---------------------------------------------------------------------------
// Gradient noise 3D assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_3D_DEFINES_SVH
`define GRADIENT_NOISE_3D_DEFINES_SVH

// Check a property on every edge outside reset.
`define GN3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gradient noise assertion failed");

// Check a property on every edge, reset included.
`define GN3_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("gradient noise assertion failed");

`endif

// ===== design/gn3_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gradient noise 3D package
// Shared widths, opcodes and table write type.
// ---------------------------------------------------------------------------
package gn3_pkg;

  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned TABLE_AW   = 8;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned NOISE_W    = 18;
  localparam int unsigned OUT_FRAC   = 16;

  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 18'sd131071;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = -18'sd131072;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef logic [TABLE_AW-1:0] perm_t;

  typedef struct packed {
    logic  we;
    perm_t waddr;
    perm_t wdata;
  } perm_wr_t;

endpackage

// ===== design/gn3_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gradient noise 3D channel interfaces
// Valid/ready channels for input items and noise samples.
// ---------------------------------------------------------------------------
interface gn3_item_if import gn3_pkg::*; ();
  logic                valid;
  logic                ready;
  op_e                 op;
  logic [TABLE_AW-1:0] table_index;
  logic [7:0]          table_value;
  logic [COORD_W-1:0]  coord_x;
  logic [COORD_W-1:0]  coord_y;
  logic [COORD_W-1:0]  coord_z;

  modport source (output valid, op, table_index, table_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, op, table_index, table_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface gn3_noise_if import gn3_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ===== design/gradient_noise_3d.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gradient noise 3D
// Improved 3D gradient noise, fixed point, one sample per clock unless stalled.
// ---------------------------------------------------------------------------
// Input channel item_i carries load transactions (op = load: write one byte
// of the permutation table) and evaluate transactions (op = eval: coords in
// unsigned fixed point with FRAC_BITS fraction bits). All 256 table entries
// must be loaded before the first evaluate.
// Output channel noise_o returns one signed Q1.16 sample per evaluate, in
// order; loads give no output.
// Throughput: one transaction per cycle unless noise_o stalls. An evaluate
// passes the three table lookup stages, with the three-stage fade alongside,
// then the gradient register and three two-stage lerp levels.
// The table is held in seven 256 x 8 copies: one for the x lookup, two for
// the second lookup and four for the corner hashes. A load writes each copy
// as it passes that lookup stage, so items keep their order.
// Reset clears all valid bits; table contents are kept and must be reloaded
// only if never written. When the receiver stalls, the whole pipeline holds
// and item_i.ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module gradient_noise_3d import gn3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gn3_item_if.sink    item_i,
  gn3_noise_if.source noise_o
);

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned GW   = F + 3;
  localparam int unsigned SH_R = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam int unsigned SH_L = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
  localparam int unsigned EW   = GW + SH_L;
  localparam logic signed [GW-1:0] ONE    = GW'(1) << F;
  localparam logic signed [GW-1:0] R_HALF =
      (SH_R > 0) ? (GW'(1) << ((SH_R > 0) ? SH_R - 1 : 0)) : '0;

  function automatic logic signed [GW-1:0] grad(input perm_t h,
                                                input logic signed [GW-1:0] x,
                                                input logic signed [GW-1:0] y,
                                                input logic signed [GW-1:0] z);
    logic [3:0]           c;
    logic signed [GW-1:0] gu, gv;
    c  = h[3:0];
    gu = (c < 4'd8) ? x : y;
    if (c < 4'd4) begin
      gv = y;
    end else if (c == 4'd12 || c == 4'd14) begin
      gv = x;
    end else begin
      gv = z;
    end
    return (c[0] ? -gu : gu) + (c[1] ? -gv : gv);
  endfunction

  // Control
  logic        adv, acc;
  logic [2:0]  ld_q;
  logic [10:0] ev_q;
  logic        out_vld_q;

  assign adv          = !out_vld_q || noise_o.ready;
  assign acc          = item_i.valid && adv;
  assign item_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_q      <= '0;
      ev_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      ld_q      <= {ld_q[1:0], acc && (item_i.op == OP_LOAD)};
      ev_q      <= {ev_q[9:0], acc && (item_i.op == OP_EVAL)};
      out_vld_q <= ev_q[10];
    end
  end

  // Payload pipeline
  perm_t        idx_q [3];
  perm_t        val_q [3];
  perm_t        xi_q;
  perm_t        yi_q [2];
  perm_t        zi_q [3];
  logic [F-1:0] fx_q [4];
  logic [F-1:0] fy_q [4];
  logic [F-1:0] fz_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx_q[0] <= item_i.table_index;
      val_q[0] <= item_i.table_value;
      xi_q     <= TABLE_AW'(item_i.coord_x >> F);
      yi_q[0]  <= TABLE_AW'(item_i.coord_y >> F);
      zi_q[0]  <= TABLE_AW'(item_i.coord_z >> F);
      fx_q[0]  <= item_i.coord_x[F-1:0];
      fy_q[0]  <= item_i.coord_y[F-1:0];
      fz_q[0]  <= item_i.coord_z[F-1:0];
      yi_q[1]  <= yi_q[0];
      for (int i = 1; i < 3; i++) begin
        idx_q[i] <= idx_q[i-1];
        val_q[i] <= val_q[i-1];
        zi_q[i]  <= zi_q[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        fx_q[i] <= fx_q[i-1];
        fy_q[i] <= fy_q[i-1];
        fz_q[i] <= fz_q[i-1];
      end
    end
  end

  // Table lookups: each stage writes its own copy as a load passes
  perm_wr_t wr [3];
  perm_t    px, px1, pa, pa1, pb, pb1;
  perm_t    a_idx, b_idx, aa, ab, ba, bb;
  perm_t    h [8];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wr[i] = '{we: ld_q[i], waddr: idx_q[i], wdata: val_q[i]};
    end
    a_idx = px + yi_q[1];
    b_idx = px1 + yi_q[1];
    aa    = pa + zi_q[2];
    ab    = pa1 + zi_q[2];
    ba    = pb + zi_q[2];
    bb    = pb1 + zi_q[2];
  end

  gn3_perm_ram u_ram_x (.clk_i, .en_i(adv), .wr_i(wr[0]), .raddr0_i(xi_q),
                        .raddr1_i(xi_q + 8'd1), .rdata0_o(px), .rdata1_o(px1));
  gn3_perm_ram u_ram_a (.clk_i, .en_i(adv), .wr_i(wr[1]), .raddr0_i(a_idx),
                        .raddr1_i(a_idx + 8'd1), .rdata0_o(pa), .rdata1_o(pa1));
  gn3_perm_ram u_ram_b (.clk_i, .en_i(adv), .wr_i(wr[1]), .raddr0_i(b_idx),
                        .raddr1_i(b_idx + 8'd1), .rdata0_o(pb), .rdata1_o(pb1));
  gn3_perm_ram u_ram_aa (.clk_i, .en_i(adv), .wr_i(wr[2]), .raddr0_i(aa),
                         .raddr1_i(aa + 8'd1), .rdata0_o(h[0]), .rdata1_o(h[4]));
  gn3_perm_ram u_ram_ba (.clk_i, .en_i(adv), .wr_i(wr[2]), .raddr0_i(ba),
                         .raddr1_i(ba + 8'd1), .rdata0_o(h[1]), .rdata1_o(h[5]));
  gn3_perm_ram u_ram_ab (.clk_i, .en_i(adv), .wr_i(wr[2]), .raddr0_i(ab),
                         .raddr1_i(ab + 8'd1), .rdata0_o(h[2]), .rdata1_o(h[6]));
  gn3_perm_ram u_ram_bb (.clk_i, .en_i(adv), .wr_i(wr[2]), .raddr0_i(bb),
                         .raddr1_i(bb + 8'd1), .rdata0_o(h[3]), .rdata1_o(h[7]));

  // Fade curves, aligned with the hashes
  logic [F:0] fu, fv, fw;

  gn3_fade #(.FRAC_BITS(F)) u_fade_x (.clk_i, .en_i(adv), .t_i(fx_q[0]), .fade_o(fu));
  gn3_fade #(.FRAC_BITS(F)) u_fade_y (.clk_i, .en_i(adv), .t_i(fy_q[0]), .fade_o(fv));
  gn3_fade #(.FRAC_BITS(F)) u_fade_z (.clk_i, .en_i(adv), .t_i(fz_q[0]), .fade_o(fw));

  // Corner gradients
  logic signed [GW-1:0] x0, y0, z0, x1, y1, z1;
  logic signed [GW-1:0] g_d [8];
  logic signed [GW-1:0] g_q [8];
  logic [F:0]           u_q;
  logic [F:0]           v_q [3];
  logic [F:0]           w_q [5];

  always_comb begin
    x0     = signed'(GW'(fx_q[3]));
    y0     = signed'(GW'(fy_q[3]));
    z0     = signed'(GW'(fz_q[3]));
    x1     = x0 - ONE;
    y1     = y0 - ONE;
    z1     = z0 - ONE;
    g_d[0] = grad(h[0], x0, y0, z0);
    g_d[1] = grad(h[1], x1, y0, z0);
    g_d[2] = grad(h[2], x0, y1, z0);
    g_d[3] = grad(h[3], x1, y1, z0);
    g_d[4] = grad(h[4], x0, y0, z1);
    g_d[5] = grad(h[5], x1, y0, z1);
    g_d[6] = grad(h[6], x0, y1, z1);
    g_d[7] = grad(h[7], x1, y1, z1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_q      <= g_d;
      u_q      <= fu;
      v_q[0]   <= fv;
      w_q[0]   <= fw;
      for (int i = 1; i < 3; i++) begin
        v_q[i] <= v_q[i-1];
      end
      for (int i = 1; i < 5; i++) begin
        w_q[i] <= w_q[i-1];
      end
    end
  end

  // Trilinear blend: x, then y, then z
  logic signed [GW-1:0] l1 [4];
  logic signed [GW-1:0] l2 [2];
  logic signed [GW-1:0] r;

  for (genvar i = 0; i < 4; i++) begin : g_lerp_x
    gn3_lerp #(.FRAC_BITS(F)) u_lerp (.clk_i, .en_i(adv), .a_i(g_q[2*i]),
                                      .b_i(g_q[2*i+1]), .w_i(u_q), .y_o(l1[i]));
  end
  for (genvar i = 0; i < 2; i++) begin : g_lerp_y
    gn3_lerp #(.FRAC_BITS(F)) u_lerp (.clk_i, .en_i(adv), .a_i(l1[2*i]),
                                      .b_i(l1[2*i+1]), .w_i(v_q[2]), .y_o(l2[i]));
  end
  gn3_lerp #(.FRAC_BITS(F)) u_lerp_z (.clk_i, .en_i(adv), .a_i(l2[0]), .b_i(l2[1]),
                                      .w_i(w_q[4]), .y_o(r));

  // Rescale to Q1.16 and saturate
  logic [GW-1:0]             mag;
  logic signed [GW-1:0]      r_m;
  logic signed [EW-1:0]      r_e;
  logic signed [NOISE_W-1:0] sat_d, noise_q;

  always_comb begin
    mag = r[GW-1] ? GW'(-r) : GW'(r);
    mag = (mag + R_HALF) >> SH_R;
    r_m = r[GW-1] ? -signed'(mag) : signed'(mag);
    r_e = EW'(r_m) <<< SH_L;
    if (r_e > EW'(NOISE_MAX)) begin
      sat_d = NOISE_MAX;
    end else if (r_e < EW'(NOISE_MIN)) begin
      sat_d = NOISE_MIN;
    end else begin
      sat_d = NOISE_W'(r_e);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      noise_q <= sat_d;
    end
  end

  assign noise_o.valid       = out_vld_q;
  assign noise_o.noise_value = noise_q;

endmodule

// ===== design/gn3_perm_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation table copy
// 256 x 8 memory, one write port and two registered read ports.
// ---------------------------------------------------------------------------
module gn3_perm_ram import gn3_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  perm_wr_t wr_i,
  input  perm_t    raddr0_i,
  input  perm_t    raddr1_i,
  output perm_t    rdata0_o,
  output perm_t    rdata1_o
);

  perm_t mem_q [TABLE_SIZE];
  perm_t rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_i.we) begin
        mem_q[wr_i.waddr] <= wr_i.wdata;
      end
      rd0_q <= mem_q[raddr0_i];
      rd1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule

// ===== design/gn3_fade.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quintic fade pipeline
// 6t^5 - 15t^4 + 10t^3 in three register stages, rounded and clamped.
// ---------------------------------------------------------------------------
module gn3_fade #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS-1:0] t_i,
  output logic [FRAC_BITS:0]   fade_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned W1 = F + 1;
  localparam int unsigned W4 = F + 4;
  localparam int unsigned W5 = F + 5;
  localparam int unsigned PW = 2 * F + 8;
  localparam logic signed [PW-1:0] ONE  = PW'(1) << F;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (F - 1);
  localparam logic signed [PW-1:0] TEN  = ONE * 10;

  // Scale a product back by 2^F, ties away from zero.
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
    logic [PW-1:0] m;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    m = (m + HALF) >> F;
    return v[PW-1] ? -signed'(m) : signed'(m);
  endfunction

  logic [F-1:0]         t1_q;
  logic [W1-1:0]        t2_q, t3_q, f_q;
  logic signed [W5-1:0] tq_q;
  logic [W4-1:0]        p_q;

  logic signed [PW-1:0] t_w, q_w, f_w;

  always_comb begin
    t_w = signed'(PW'(t_i));
    q_w = (t_w <<< 2) + (t_w <<< 1) - (ONE <<< 4) + ONE;
    f_w = rnd(signed'(PW'(t3_q)) * signed'(PW'(p_q)));
    if (f_w < 0) begin
      f_w = '0;
    end else if (f_w > ONE) begin
      f_w = ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= t_i;
      t2_q <= W1'(rnd(t_w * t_w));
      tq_q <= W5'(rnd(t_w * q_w));
      t3_q <= W1'(rnd(signed'(PW'(t2_q)) * signed'(PW'(t1_q))));
      p_q  <= W4'(PW'(tq_q) + TEN);
      f_q  <= W1'(f_w);
    end
  end

  assign fade_o = f_q;

endmodule

// ===== design/gn3_lerp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Linear interpolation stage
// a + w*(b - a) with rounded product, two register stages.
// ---------------------------------------------------------------------------
module gn3_lerp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [FRAC_BITS+2:0] a_i,
  input  logic signed [FRAC_BITS+2:0] b_i,
  input  logic        [FRAC_BITS:0]   w_i,
  output logic signed [FRAC_BITS+2:0] y_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned GW = F + 3;
  localparam int unsigned PW = 2 * F + 8;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (F - 1);

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
    logic [PW-1:0] m;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    m = (m + HALF) >> F;
    return v[PW-1] ? -signed'(m) : signed'(m);
  endfunction

  logic signed [PW-1:0] prod_q;
  logic signed [GW-1:0] a_q, y_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= signed'(PW'(w_i)) * (PW'(b_i) - PW'(a_i));
      a_q    <= a_i;
      y_q    <= a_q + GW'(rnd(prod_q));
    end
  end

  assign y_o = y_q;

endmodule

// ===== design/gn3_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gradient noise 3D port checker
// Watches the top-level handshakes and the stall behavior.
// ---------------------------------------------------------------------------
`include "gradient_noise_3d_defines.svh"

module gn3_checker import gn3_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [NOISE_W-1:0] out_value_i
);

  // A stalled sample holds its value
  `GN3_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))

  // Empty output register always takes a transaction
  `GN3_ASSERT_ALWAYS(a_ready_empty, !out_valid_i |-> in_ready_i)

  // A stalled output freezes the pipeline
  `GN3_ASSERT(a_ready_stall, out_valid_i && !out_ready_i |-> !in_ready_i)

endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (item_i.ready),
  .out_valid_i (noise_o.valid),
  .out_ready_i (noise_o.ready),
  .out_value_i (noise_o.noise_value)
);
